// File: rtl/core/cse_pkg.sv
package cse_pkg;

  // frame geometry
  localparam int FRAME_BYTES = 9;
  localparam int IDX_W       = $clog2(FRAME_BYTES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_BYTES - 1);

  // actions
  localparam logic [1:0] ACT_READ = 2'd0;
  localparam logic [1:0] ACT_CAL  = 2'd1;
  localparam logic [1:0] ACT_BYTE = 2'd2;
  localparam logic [1:0] ACT_TICK = 2'd3;

  // completion status codes
  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_TIMEOUT = 2'd1;
  localparam logic [1:0] STAT_BAD_HDR = 2'd2;
  localparam logic [1:0] STAT_BAD_CKS = 2'd3;

  // result kinds
  localparam logic KIND_TX     = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // descriptor kinds handed from the control to the serializer
  localparam logic [1:0] DESC_READ   = 2'd0;
  localparam logic [1:0] DESC_CAL    = 2'd1;
  localparam logic [1:0] DESC_STATUS = 2'd2;

  // register map
  localparam logic REG_TIMEOUT = 1'b0;
  localparam logic [15:0] TIMEOUT_RESET = 16'd200;

  // protocol bytes
  localparam logic [7:0] HDR_START  = 8'hFF;
  localparam logic [7:0] HDR_SENSOR = 8'h01;
  localparam logic [7:0] CMD_READ   = 8'h86;
  localparam logic [7:0] CMD_ABC    = 8'h79;
  localparam logic [7:0] ABC_ON     = 8'hA0;
  localparam logic [7:0] ABC_OFF    = 8'h00;
  localparam logic [7:0] READ_CKS   = 8'h79;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] rx_byte;
    logic       abc_enable;
  } cse_in_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  tx_byte;
    logic        last;
    logic [1:0]  status;
    logic [15:0] co2_ppm;
  } cse_out_t;

  typedef struct packed {
    logic [1:0]  desc_kind;
    logic        abc;
    logic [1:0]  status;
    logic [15:0] ppm;
  } cse_desc_t;

  // byte idx of a command frame
  function automatic logic [7:0] frame_byte(input logic [1:0] desc_kind, input logic abc,
                                            input logic [IDX_W-1:0] idx);
    logic [7:0] b3;
    logic [7:0] b;
    b3 = abc ? ABC_ON : ABC_OFF;
    b  = 8'h00;
    case (idx)
      IDX_W'(0): b = HDR_START;
      IDX_W'(1): b = HDR_SENSOR;
      IDX_W'(2): b = (desc_kind == DESC_CAL) ? CMD_ABC : CMD_READ;
      IDX_W'(3): b = (desc_kind == DESC_CAL) ? b3 : 8'h00;
      IDX_W'(8): b = (desc_kind == DESC_CAL) ? 8'(8'h00 - (HDR_SENSOR + CMD_ABC + b3))
                                             : READ_CKS;
      default:   b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// File: rtl/core/cse_cfg.sv
module cse_cfg (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [15:0] timeout_ticks
);
  import cse_pkg::*;

  logic wr_en;

  assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_TIMEOUT);
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= TIMEOUT_RESET;
    end else if (wr_en) begin
      timeout_ticks <= pwdata[15:0];
    end
  end

  always_comb begin
    if (paddr[2] == REG_TIMEOUT) begin
      prdata = {16'h0000, timeout_ticks};
    end else begin
      prdata = 32'h0000_0000;
    end
  end

endmodule

// File: rtl/core/cse_ctrl.sv
module cse_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  cse_pkg::cse_in_t  item,
  input  logic [15:0]       timeout_ticks,
  output logic              desc_valid,
  output cse_pkg::cse_desc_t desc
);
  import cse_pkg::*;

  logic             waiting, waiting_next;
  logic [IDX_W-1:0] byte_count, byte_count_next;
  logic [15:0]      tick_count, tick_count_next;
  logic [7:0]       running_sum, running_sum_next;
  logic             header_ok, header_ok_next;
  logic [7:0]       ppm_high, ppm_high_next;
  logic [7:0]       ppm_low, ppm_low_next;
  logic [15:0]      tick_inc;

  assign tick_inc = (tick_count != 16'hFFFF) ? 16'(tick_count + 16'd1) : tick_count;

  always_comb begin
    waiting_next     = waiting;
    byte_count_next  = byte_count;
    tick_count_next  = tick_count;
    running_sum_next = running_sum;
    header_ok_next   = header_ok;
    ppm_high_next    = ppm_high;
    ppm_low_next     = ppm_low;
    desc_valid       = 1'b0;
    desc             = '0;
    case (item.action)
      ACT_READ: begin
        waiting_next     = 1'b1;
        byte_count_next  = '0;
        tick_count_next  = '0;
        running_sum_next = '0;
        header_ok_next   = 1'b1;
        ppm_high_next    = '0;
        ppm_low_next     = '0;
        desc_valid       = 1'b1;
        desc.desc_kind   = DESC_READ;
      end
      ACT_CAL: begin
        if (!waiting) begin
          desc_valid     = 1'b1;
          desc.desc_kind = DESC_CAL;
          desc.abc       = item.abc_enable;
        end
      end
      ACT_BYTE: begin
        if (waiting) begin
          if (byte_count == IDX_W'(0) && item.rx_byte != HDR_START) header_ok_next = 1'b0;
          if (byte_count == IDX_W'(1) && item.rx_byte != CMD_READ)  header_ok_next = 1'b0;
          if (byte_count == IDX_W'(2)) ppm_high_next = item.rx_byte;
          if (byte_count == IDX_W'(3)) ppm_low_next  = item.rx_byte;
          if (byte_count != IDX_W'(0) && byte_count != LAST_IDX) begin
            running_sum_next = 8'(running_sum + item.rx_byte);
          end
          if (byte_count != LAST_IDX) begin
            byte_count_next = IDX_W'(byte_count + IDX_W'(1));
          end else begin
            // ninth byte closes the response
            waiting_next    = 1'b0;
            byte_count_next = '0;
            desc_valid      = 1'b1;
            desc.desc_kind  = DESC_STATUS;
            if (!header_ok) begin
              desc.status = STAT_BAD_HDR;
            end else if (item.rx_byte != 8'(8'h00 - running_sum)) begin
              desc.status = STAT_BAD_CKS;
            end else begin
              desc.status = STAT_OK;
              desc.ppm    = {ppm_high, ppm_low};
            end
          end
        end
      end
      ACT_TICK: begin
        if (waiting) begin
          tick_count_next = tick_inc;
          if (tick_inc >= timeout_ticks) begin
            waiting_next    = 1'b0;
            byte_count_next = '0;
            desc_valid      = 1'b1;
            desc.desc_kind  = DESC_STATUS;
            desc.status     = STAT_TIMEOUT;
          end
        end
      end
      default: begin
        desc_valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      waiting     <= 1'b0;
      byte_count  <= '0;
      tick_count  <= '0;
      running_sum <= '0;
      header_ok   <= 1'b1;
      ppm_high    <= '0;
      ppm_low     <= '0;
    end else if (fire) begin
      waiting     <= waiting_next;
      byte_count  <= byte_count_next;
      tick_count  <= tick_count_next;
      running_sum <= running_sum_next;
      header_ok   <= header_ok_next;
      ppm_high    <= ppm_high_next;
      ppm_low     <= ppm_low_next;
    end
  end

  a_idle_count: assert property (@(posedge clk) disable iff (rst)
    !waiting |-> byte_count == '0)
    else $error("byte count nonzero while idle");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    byte_count <= LAST_IDX)
    else $error("byte count past frame end");

endmodule

// File: rtl/core/cse_tx.sv
module cse_tx (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  cse_pkg::cse_desc_t desc,
  output logic               free,
  output logic               out_valid,
  input  logic               out_ready,
  output cse_pkg::cse_out_t  out_data
);
  import cse_pkg::*;

  logic             a_valid;
  cse_desc_t        a_desc;
  logic [IDX_W-1:0] a_idx;
  logic [IDX_W-1:0] a_last;
  logic             beat_move;
  logic             a_done;
  cse_out_t         beat;

  assign a_last    = (a_desc.desc_kind == DESC_STATUS) ? IDX_W'(0) : LAST_IDX;
  assign beat_move = a_valid && (!out_valid || out_ready);
  assign a_done    = beat_move && (a_idx == a_last);
  assign free      = !a_valid || a_done;

  always_comb begin
    beat = '0;
    if (a_desc.desc_kind == DESC_STATUS) begin
      beat.kind    = KIND_STATUS;
      beat.last    = 1'b1;
      beat.status  = a_desc.status;
      beat.co2_ppm = a_desc.ppm;
    end else begin
      beat.kind    = KIND_TX;
      beat.tx_byte = frame_byte(a_desc.desc_kind, a_desc.abc, a_idx);
      beat.last    = (a_idx == LAST_IDX);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      a_idx     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        a_valid <= 1'b1;
        a_idx   <= '0;
      end else if (a_done) begin
        a_valid <= 1'b0;
      end else if (beat_move) begin
        a_idx <= IDX_W'(a_idx + IDX_W'(1));
      end
      if (beat_move) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      a_desc <= desc;
    end
    if (beat_move) begin
      out_data <= beat;
    end
  end

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    a_valid |-> a_idx <= a_last)
    else $error("serializer index past descriptor end");

  a_status_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.kind == KIND_STATUS) |-> out_data.last)
    else $error("status transaction without last");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    a_done && !load |=> !a_valid)
    else $error("serializer busy after final beat");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

endmodule

// File: rtl/core/co2_sensor_frame_engine.sv
// Framing engine for a nine-byte UART CO2 sensor protocol. Each input
// transaction carries one action: start a read (emits the nine-byte read
// command and arms the response collector), send the auto-calibration
// command (nine bytes, checksum derived from abc_enable, dropped while a read
// is pending), deliver one received byte, or advance the timeout tick. A read
// finishes with exactly one status transaction (ok with co2_ppm, timeout, bad
// header, or bad checksum). Received bytes and ticks are folded into the
// state in the cycle they are accepted; results go out through a serializer
// and an output register, so a stalled output does not hold off the input
// until the serializer itself is occupied. Rate: any action is taken when
// the serializer is empty or on its final beat, so while it is idle one
// transaction goes in per cycle. A command frame occupies the serializer for
// all nine bytes (one byte per cycle on the output while it is not stalled)
// and a status result for its single beat; every action that arrives behind
// a frame waits, even one that makes no result; output stalls prolong the wait.
// timeout_ticks sits at byte address 0 of the register port, resets to 200,
// and a new value applies at the next tick.
module co2_sensor_frame_engine (
  input  logic              clk,
  input  logic              rst,
  // input channel
  input  logic              in_valid,
  output logic              in_ready,
  input  cse_pkg::cse_in_t  in_data,
  // result channel
  output logic              out_valid,
  input  logic              out_ready,
  output cse_pkg::cse_out_t out_data,
  // register port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import cse_pkg::*;

  logic        accept;
  logic        desc_valid;
  cse_desc_t   desc;
  logic        tx_free;
  logic [15:0] timeout_ticks;

  // a transaction is taken whenever the serializer can absorb what it makes
  assign in_ready = tx_free;
  assign accept   = in_valid && in_ready;

  // configuration register
  cse_cfg u_cfg (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .timeout_ticks (timeout_ticks)
  );

  // protocol state, updated in the accept cycle
  cse_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .fire          (accept),
    .item          (in_data),
    .timeout_ticks (timeout_ticks),
    .desc_valid    (desc_valid),
    .desc          (desc)
  );

  // frame / status serializer with output register
  cse_tx u_tx (
    .clk       (clk),
    .rst       (rst),
    .load      (accept && desc_valid),
    .desc      (desc),
    .free      (tx_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
